@@ rtl/swrl_pkg.sv @@
// Shared constants and control/status types for the sliding window rate limiter.
`default_nettype none

package swrl_pkg;

    // Storage sizing
    localparam int MAX_PERIODS   = 64;
    localparam int COUNT_WIDTH   = 16;

    // Field and register widths
    localparam int TIME_W        = 40;
    localparam int PERIOD_W      = 16;
    localparam int PPW_W         = 7;
    localparam int MAXEV_W       = 16;
    localparam int WCOUNT_W      = 16;
    localparam int M_TDATA_W     = 24;

    // Derived widths
    localparam int IDX_W         = $clog2(MAX_PERIODS);
    localparam int WIN_W         = $clog2(MAX_PERIODS + 1);
    localparam int N_W           = $clog2(MAX_PERIODS + 3);
    localparam int SUM_W         = COUNT_WIDTH + $clog2(MAX_PERIODS);
    localparam int CMP_W         = (SUM_W > MAXEV_W) ? SUM_W : MAXEV_W;
    localparam int DIV_CNT_W     = $clog2(TIME_W + 1);

    localparam int CATCHUP_EXTRA = 2;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [WCOUNT_W-1:0]    OUT_MAX   = {WCOUNT_W{1'b1}};

    // Configuration port
    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;
    localparam logic [1:0] REG_PERIOD     = 2'd0;
    localparam logic [1:0] REG_WINDOW     = 2'd1;
    localparam logic [1:0] REG_MAX_EVENTS = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(60);
    localparam logic [PPW_W-1:0]    PPW_RST    = PPW_W'(60);
    localparam logic [MAXEV_W-1:0]  MAXEV_RST  = MAXEV_W'(60);

    // Divider operand select
    localparam logic DIV_SEL_TIME = 1'b0;
    localparam logic DIV_SEL_WIN  = 1'b1;

    typedef struct packed {
        logic div_start;
        logic div_sel;
        logic cap_cur;
        logic cap_mod;
        logic span;
        logic clr_step;
        logic sum_run;
        logic update;
    } swrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic clr_done;
        logic sum_done;
        logic out_free;
    } swrl_sts_t;

    typedef struct packed {
        logic [MAXEV_W-1:0]  max_events;
        logic [PPW_W-1:0]    periods_per_window;
        logic [PERIOD_W-1:0] period_seconds;
    } swrl_cfg_t;

endpackage

`default_nettype wire

@@ rtl/swrl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module swrl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/swrl_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module swrl_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [swrl_pkg::TIME_W-1:0]   dividend,
    input  wire logic [swrl_pkg::PERIOD_W-1:0] divisor,
    output logic                               done,
    output logic      [swrl_pkg::TIME_W-1:0]   quotient,
    output logic      [swrl_pkg::PERIOD_W-1:0] remainder
);

    logic [swrl_pkg::TIME_W-1:0]    quo_reg;
    logic [swrl_pkg::PERIOD_W-1:0]  rem_reg;
    logic [swrl_pkg::PERIOD_W-1:0]  dvs_reg;
    logic [swrl_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           done_reg;

    logic [swrl_pkg::PERIOD_W:0] rem_shift;
    logic [swrl_pkg::PERIOD_W:0] rem_sub;
    logic                        fits;

    assign rem_shift = {rem_reg, quo_reg[swrl_pkg::TIME_W-1]};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};
    assign fits      = rem_shift >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == swrl_pkg::DIV_CNT_W'(1)) && !start;
            if (start) begin
                cnt_reg <= swrl_pkg::DIV_CNT_W'(swrl_pkg::TIME_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - swrl_pkg::DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (cnt_reg != '0) begin
            quo_reg <= {quo_reg[swrl_pkg::TIME_W-2:0], fits};
            rem_reg <= fits ? rem_sub[swrl_pkg::PERIOD_W-1:0]
                            : rem_shift[swrl_pkg::PERIOD_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

@@ rtl/swrl_dp.sv @@
// Datapath: period division, bucket ring with valid bits, window sum and result register.
`default_nettype none

module swrl_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire swrl_pkg::swrl_cmd_t               cmd,
    output swrl_pkg::swrl_sts_t                    sts,
    input  wire swrl_pkg::swrl_cfg_t               cfg,
    input  wire logic [swrl_pkg::TIME_W-1:0]       in_time,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [swrl_pkg::M_TDATA_W-1:0]    m_tdata
);

    // Effective configuration
    logic [swrl_pkg::PERIOD_W-1:0] period_eff;
    logic [swrl_pkg::WIN_W-1:0]    win_eff;

    assign period_eff = (cfg.period_seconds == '0) ? swrl_pkg::PERIOD_W'(1)
                                                   : cfg.period_seconds;

    always_comb begin
        if (cfg.periods_per_window == '0) begin
            win_eff = swrl_pkg::WIN_W'(1);
        end else if (32'(cfg.periods_per_window) > 32'(swrl_pkg::MAX_PERIODS)) begin
            win_eff = swrl_pkg::WIN_W'(swrl_pkg::MAX_PERIODS);
        end else begin
            win_eff = swrl_pkg::WIN_W'(cfg.periods_per_window);
        end
    end

    // Shared divider
    logic                          div_done;
    logic [swrl_pkg::TIME_W-1:0]   div_quo;
    logic [swrl_pkg::PERIOD_W-1:0] div_rem;
    logic [swrl_pkg::TIME_W-1:0]   div_dividend;
    logic [swrl_pkg::PERIOD_W-1:0] div_divisor;

    assign div_dividend = (cmd.div_sel == swrl_pkg::DIV_SEL_WIN) ? div_quo : in_time;
    assign div_divisor  = (cmd.div_sel == swrl_pkg::DIV_SEL_WIN)
                        ? swrl_pkg::PERIOD_W'(win_eff) : period_eff;

    swrl_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Period bookkeeping
    logic [swrl_pkg::TIME_W-1:0] current_reg;
    logic [swrl_pkg::TIME_W-1:0] last_reg;
    logic [swrl_pkg::IDX_W-1:0]  cur_mod_reg;
    logic [swrl_pkg::N_W-1:0]    n_reg;
    logic [swrl_pkg::N_W-1:0]    n_next;
    logic [swrl_pkg::IDX_W-1:0]  clr_idx_reg;

    logic [swrl_pkg::TIME_W:0]   diff;
    logic [swrl_pkg::N_W-1:0]    cap;
    logic                        ahead;

    assign diff  = {1'b0, current_reg} - {1'b0, last_reg};
    assign ahead = !diff[swrl_pkg::TIME_W] && (diff != '0);
    assign cap   = swrl_pkg::N_W'(win_eff) + swrl_pkg::N_W'(swrl_pkg::CATCHUP_EXTRA);

    always_comb begin
        if (!ahead) begin
            n_next = '0;
        end else if (diff > (swrl_pkg::TIME_W + 1)'(cap)) begin
            n_next = cap;
        end else begin
            n_next = diff[swrl_pkg::N_W-1:0];
        end
    end

    // Bucket store
    logic [swrl_pkg::MAX_PERIODS-1:0] valid_reg;
    logic                             ram_we;
    logic [swrl_pkg::COUNT_WIDTH-1:0] ram_wdata;
    logic [swrl_pkg::IDX_W-1:0]       ram_raddr;
    logic [swrl_pkg::COUNT_WIDTH-1:0] ram_rdata;

    // Window sum
    logic [swrl_pkg::WIN_W-1:0]       issue_cnt_reg;
    logic                             pend_reg;
    logic [swrl_pkg::IDX_W-1:0]       pend_idx_reg;
    logic [swrl_pkg::SUM_W-1:0]       sum_reg;
    logic [swrl_pkg::COUNT_WIDTH-1:0] slot_val_reg;
    logic                             issue;
    logic [swrl_pkg::COUNT_WIDTH-1:0] rd_val;

    assign issue     = cmd.sum_run && (issue_cnt_reg < win_eff);
    assign ram_raddr = issue_cnt_reg[swrl_pkg::IDX_W-1:0];
    assign rd_val    = valid_reg[pend_idx_reg] ? ram_rdata : '0;

    // Admission decision
    logic [swrl_pkg::CMP_W-1:0]  sum_ext;
    logic                        accepted;
    logic [swrl_pkg::WCOUNT_W-1:0] wcount;

    assign sum_ext  = swrl_pkg::CMP_W'(sum_reg);
    assign accepted = sum_ext < swrl_pkg::CMP_W'(cfg.max_events);
    assign wcount   = (sum_ext > swrl_pkg::CMP_W'(swrl_pkg::OUT_MAX))
                    ? swrl_pkg::OUT_MAX : sum_ext[swrl_pkg::WCOUNT_W-1:0];

    assign ram_we    = cmd.update && accepted;
    assign ram_wdata = (slot_val_reg < swrl_pkg::COUNT_MAX)
                     ? slot_val_reg + swrl_pkg::COUNT_WIDTH'(1) : slot_val_reg;

    swrl_ram #(
        .WIDTH (swrl_pkg::COUNT_WIDTH),
        .DEPTH (swrl_pkg::MAX_PERIODS)
    ) u_buckets (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cur_mod_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result register
    logic                          m_valid_reg;
    logic                          m_acc_reg;
    logic [swrl_pkg::WCOUNT_W-1:0] m_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg      <= '0;
            valid_reg     <= '0;
            n_reg         <= '0;
            issue_cnt_reg <= '0;
            pend_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.span) begin
                last_reg <= current_reg;
                n_reg    <= n_next;
            end else if (cmd.clr_step) begin
                n_reg <= n_reg - swrl_pkg::N_W'(1);
            end

            // drop cleared buckets, mark the written one
            if (cmd.clr_step) begin
                valid_reg[clr_idx_reg] <= 1'b0;
            end else if (ram_we) begin
                valid_reg[cur_mod_reg] <= 1'b1;
            end

            if (cmd.span) begin
                issue_cnt_reg <= '0;
                pend_reg      <= 1'b0;
            end else if (cmd.sum_run) begin
                pend_reg <= issue;
                if (issue) begin
                    issue_cnt_reg <= issue_cnt_reg + swrl_pkg::WIN_W'(1);
                end
            end

            if (cmd.update) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_cur) begin
            current_reg <= div_quo;
        end
        if (cmd.cap_mod) begin
            cur_mod_reg <= div_rem[swrl_pkg::IDX_W-1:0];
        end
        if (cmd.span) begin
            clr_idx_reg <= cur_mod_reg;
            sum_reg     <= '0;
        end else if (cmd.clr_step) begin
            // walk backward through the ring, wrapping at the window size
            clr_idx_reg <= (clr_idx_reg == '0)
                         ? swrl_pkg::IDX_W'(win_eff - swrl_pkg::WIN_W'(1))
                         : clr_idx_reg - swrl_pkg::IDX_W'(1);
        end
        if (issue) begin
            pend_idx_reg <= ram_raddr;
        end
        if (cmd.sum_run && pend_reg) begin
            sum_reg <= sum_reg + swrl_pkg::SUM_W'(rd_val);
            if (pend_idx_reg == cur_mod_reg) begin
                slot_val_reg <= rd_val;
            end
        end
        if (cmd.update) begin
            m_acc_reg <= accepted;
            m_cnt_reg <= wcount;
        end
    end

    assign sts.div_done = div_done;
    assign sts.clr_done = (n_reg == '0);
    assign sts.sum_done = (issue_cnt_reg >= win_eff) && !pend_reg;
    assign sts.out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = swrl_pkg::M_TDATA_W'({m_cnt_reg, m_acc_reg});

endmodule

`default_nettype wire

@@ rtl/swrl_ctrl.sv @@
// Controller: sequences division, bucket clearing, window sum and update for each item.
`default_nettype none

module swrl_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output swrl_pkg::swrl_cmd_t      cmd,
    input  wire swrl_pkg::swrl_sts_t sts
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DIV_T  = 7'b0000010,
        ST_DIV_W  = 7'b0000100,
        ST_SPAN   = 7'b0001000,
        ST_CLEAR  = 7'b0010000,
        ST_SUM    = 7'b0100000,
        ST_UPDATE = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = swrl_pkg::DIV_SEL_TIME;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_T;
                end
            end
            ST_DIV_T: begin
                if (sts.div_done) begin
                    cmd.cap_cur   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = swrl_pkg::DIV_SEL_WIN;
                    state_next    = ST_DIV_W;
                end
            end
            ST_DIV_W: begin
                if (sts.div_done) begin
                    cmd.cap_mod = 1'b1;
                    state_next  = ST_SPAN;
                end
            end
            ST_SPAN: begin
                cmd.span   = 1'b1;
                state_next = ST_CLEAR;
            end
            ST_CLEAR: begin
                if (sts.clr_done) begin
                    state_next = ST_SUM;
                end else begin
                    cmd.clr_step = 1'b1;
                end
            end
            ST_SUM: begin
                cmd.sum_run = 1'b1;
                if (sts.sum_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // hold until the result register can take the item
                if (sts.out_free) begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

@@ rtl/sliding_window_rate_limiter.sv @@
// Top level: configuration registers, controller and datapath of the rate limiter.
//
// Each input item carries a 40-bit time in seconds and yields one result item:
// an accept flag and the saturated count of events in the window before this
// one. Items are handled one at a time. An item goes through two serial divisions
// on one shared one-bit-per-cycle divider (time by the period length, then
// period number by the window size), then clears the buckets of the periods
// passed one by one (up to window+2), then sums the buckets through the single
// read port of the bucket RAM, then waits until the result register is free.
// The buckets come out of reset empty through per-bucket valid bits, so no
// clearing pass is needed and the first item is taken right after reset. The
// result register holds one finished item while the next one is accepted and
// processed.
`default_nettype none

module sliding_window_rate_limiter (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [swrl_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [swrl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [swrl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    // input items
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [swrl_pkg::TIME_W-1:0]       s_tdata,   // [39:0] time_seconds
    // result items
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [swrl_pkg::M_TDATA_W-1:0]    m_tdata    // [0] accepted,
                                                              // [16:1] window_count
);

    swrl_pkg::swrl_cfg_t cfg_reg;
    swrl_pkg::swrl_cmd_t cmd;
    swrl_pkg::swrl_sts_t sts;

    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.period_seconds     <= swrl_pkg::PERIOD_RST;
            cfg_reg.periods_per_window <= swrl_pkg::PPW_RST;
            cfg_reg.max_events         <= swrl_pkg::MAXEV_RST;
        end else if (wr_en) begin
            case (reg_idx)
                swrl_pkg::REG_PERIOD: begin
                    cfg_reg.period_seconds <= pwdata[swrl_pkg::PERIOD_W-1:0];
                end
                swrl_pkg::REG_WINDOW: begin
                    cfg_reg.periods_per_window <= pwdata[swrl_pkg::PPW_W-1:0];
                end
                swrl_pkg::REG_MAX_EVENTS: begin
                    cfg_reg.max_events <= pwdata[swrl_pkg::MAXEV_W-1:0];
                end
                default: begin
                    // unmapped address: drop the write
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            swrl_pkg::REG_PERIOD: begin
                prdata = swrl_pkg::APB_DATA_W'(cfg_reg.period_seconds);
            end
            swrl_pkg::REG_WINDOW: begin
                prdata = swrl_pkg::APB_DATA_W'(cfg_reg.periods_per_window);
            end
            swrl_pkg::REG_MAX_EVENTS: begin
                prdata = swrl_pkg::APB_DATA_W'(cfg_reg.max_events);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    swrl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    swrl_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .cfg      (cfg_reg),
        .in_time  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

@@ bench/tb_sliding_window_rate_limiter.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the sliding window rate limiter.
module tb_sliding_window_rate_limiter;
    import swrl_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_CYCLES = 300;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 240;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef struct packed {
        logic                accepted;
        logic [WCOUNT_W-1:0] window_count;
    } verdict_t;

    typedef struct packed {
        logic              drain_first;
        logic [TIME_W-1:0] stamp;
    } event_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TIME_W-1:0]     s_tdata = '0;    // [39:0] time_seconds
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // [0] accepted, [16:1] window_count

    // Shadow registers and bucket state of the limiter
    logic [PERIOD_W-1:0]    cfg_period = PERIOD_RST;
    logic [PPW_W-1:0]       cfg_window = PPW_RST;
    logic [MAXEV_W-1:0]     cfg_max = MAXEV_RST;
    logic [TIME_W-1:0]      seen_period = '0;
    logic [COUNT_WIDTH-1:0] bucket_tally [MAX_PERIODS];

    event_t      pending_events[$];
    verdict_t    expected_verdicts[$];
    verdict_t    want;
    int unsigned n_issued = 0;
    int unsigned n_checked = 0;
    int unsigned mismatch_count = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned draw;
    logic        idle_on = 1'b1;

    // stimulus scratch
    int               ph;
    int               k;
    int unsigned      r;
    int unsigned      eff_period;
    int unsigned      eff_window;
    logic [TIME_W-1:0] t_clock;
    logic [TIME_W-1:0] back;
    logic [PERIOD_W-1:0] new_period;
    logic [PPW_W-1:0]    new_window;
    logic [MAXEV_W-1:0]  new_max;

    sliding_window_rate_limiter i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    initial begin
        for (int i = 0; i < MAX_PERIODS; i++) begin
            bucket_tally[i] = '0;
        end
    end

    // Advance the bucket ring to the period of this event and decide admission
    function automatic void rate_decide(input logic [TIME_W-1:0] stamp);
        logic [63:0] divisor;
        logic [63:0] win;
        logic [63:0] cur;
        logic [63:0] prev;
        logic [63:0] p;
        logic [63:0] slot;
        logic [63:0] sum;
        verdict_t    v;
        divisor = (cfg_period == '0) ? 64'd1 : 64'(cfg_period);
        win = (cfg_window == '0) ? 64'd1 :
              (cfg_window > MAX_PERIODS) ? 64'(MAX_PERIODS) : 64'(cfg_window);
        cur = 64'(stamp) / divisor;
        prev = 64'(seen_period);
        // cap catch-up so a long silence clears the ring only once
        if (cur > prev && cur - prev > win + CATCHUP_EXTRA) begin
            prev = cur - win - CATCHUP_EXTRA;
        end
        for (p = prev + 1; p <= cur; p++) begin
            bucket_tally[p % win] = '0;
        end
        seen_period = cur[TIME_W-1:0];
        slot = cur % win;
        sum = 0;
        for (int i = 0; i < win; i++) begin
            sum += 64'(bucket_tally[i]);
        end
        v.accepted = (sum < 64'(cfg_max));
        if (v.accepted && bucket_tally[slot] != COUNT_MAX) begin
            bucket_tally[slot] = bucket_tally[slot] + 1'b1;
        end
        v.window_count = (sum > 64'(OUT_MAX)) ? OUT_MAX : sum[WCOUNT_W-1:0];
        expected_verdicts.push_back(v);
    endfunction

    task automatic report(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_PERIOD:     cfg_period = value[PERIOD_W-1:0];
            REG_WINDOW:     cfg_window = value[PPW_W-1:0];
            REG_MAX_EVENTS: cfg_max = value[MAXEV_W-1:0];
            default: ;
        endcase
    endtask

    // Upper bits of each write are random so the field masking is exercised
    task automatic apply_config(input logic [PERIOD_W-1:0] per, input logic [PPW_W-1:0] win,
                                input logic [MAXEV_W-1:0] mx);
        write_reg(REG_PERIOD, ($urandom & 32'hFFFF_0000) | 32'(per));
        write_reg(REG_WINDOW, ($urandom & 32'hFFFF_FF80) | 32'(win));
        write_reg(REG_MAX_EVENTS, ($urandom & 32'hFFFF_0000) | 32'(mx));
    endtask

    task automatic queue_event(input logic [TIME_W-1:0] stamp, input logic drain);
        event_t e;
        e.drain_first = drain;
        e.stamp = stamp;
        pending_events.push_back(e);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_events.size() != 0 || s_tvalid || n_issued != n_checked);
    endtask

    // Driver: present queued events, idling between them while the block can take one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                rate_decide(s_tdata);
                n_issued <= n_issued + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    s_tvalid <= 1'b0;
                    if (s_tready) begin
                        gap_left <= gap_left - 1;
                    end
                end else if (pending_events.size() != 0 &&
                             !(pending_events[0].drain_first &&
                               (n_issued != n_checked || s_tvalid))) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_events[0].stamp;
                    void'(pending_events.pop_front());
                    gap_left <= idle_on ? $urandom_range(0, 3) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result item against the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else if (m_tvalid && m_tready) begin
            if (expected_verdicts.size() == 0) begin
                report($sformatf("unexpected result item: accepted=%0d count=%0d",
                                 m_tdata[0], m_tdata[16:1]));
            end else begin
                want = expected_verdicts.pop_front();
                if (m_tdata[0] !== want.accepted || m_tdata[16:1] !== want.window_count) begin
                    report($sformatf({"mismatch: expected accepted=%0d count=%0d, ",
                                      "got accepted=%0d count=%0d"},
                                     want.accepted, want.window_count,
                                     m_tdata[0], m_tdata[16:1]));
                end
            end
            n_checked <= n_checked + 1;
            draw = idle_on ? $urandom_range(0, 3) : 0;
            stall_left <= draw;
            m_tready <= (draw == 0);
        end else if (stall_left != 0) begin
            // stall only while a result item is waiting
            if (m_tvalid) begin
                stall_left <= stall_left - 1;
                m_tready <= (stall_left == 1);
            end
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pwrite && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: period boundaries, time extremes, time going backwards
        @(negedge aclk);
        queue_event(40'd0, 1'b0);
        queue_event(40'd0, 1'b0);
        queue_event(40'd59, 1'b0);
        queue_event(40'd60, 1'b0);
        queue_event(40'd3599, 1'b0);
        queue_event(40'd3600, 1'b0);
        queue_event(40'd3660, 1'b0);
        queue_event(TIME_MAX, 1'b0);
        queue_event(40'd100, 1'b0);
        wait_drained();

        // zero period length and zero window size, tight limit
        apply_config('0, '0, 16'd2);
        @(negedge aclk);
        queue_event(40'd5, 1'b0);
        queue_event(40'd5, 1'b0);
        queue_event(40'd5, 1'b0);
        queue_event(40'd6, 1'b0);
        queue_event(40'd6, 1'b0);
        queue_event(40'd8, 1'b0);
        wait_drained();

        // oversize window, longest period, nothing allowed; stray register index ignored
        write_reg(REG_UNUSED, $urandom);
        apply_config(16'hFFFF, 7'h7F, '0);
        @(negedge aclk);
        queue_event(TIME_MAX, 1'b0);
        queue_event(40'd0, 1'b0);
        queue_event(40'd65535 * 70, 1'b0);
        wait_drained();

        // shortest period, full window, widest limit
        apply_config(16'd1, 7'd64, 16'hFFFF);
        @(negedge aclk);
        queue_event(40'd1, 1'b0);
        queue_event(40'd2, 1'b0);
        queue_event(40'd2, 1'b0);
        queue_event(40'd200, 1'b0);
        queue_event(40'd10, 1'b0);

        t_clock = 40'd10;
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: apply_config(16'd1, 7'd1, 16'd1);
                1: apply_config(16'hFFFF, 7'd64, 16'hFFFF);
                default: begin
                    case ($urandom_range(0, 3))
                        0: new_period = PERIOD_W'($urandom_range(1, 8));
                        1: new_period = PERIOD_W'($urandom_range(1, 300));
                        2: new_period = '0;
                        default: new_period = PERIOD_W'($urandom_range(1, 65535));
                    endcase
                    new_window = PPW_W'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 16)
                                                                   : $urandom_range(0, 127));
                    case ($urandom_range(0, 3))
                        0: new_max = MAXEV_W'($urandom_range(0, 3));
                        1: new_max = MAXEV_W'($urandom_range(1, 40));
                        2: new_max = MAXEV_W'($urandom_range(0, 65535));
                        default: new_max = 16'hFFFF;
                    endcase
                    apply_config(new_period, new_window, new_max);
                end
            endcase
            @(negedge aclk);
            idle_on = ($urandom_range(0, 3) != 0);
            eff_period = (cfg_period == '0) ? 1 : 32'(cfg_period);
            eff_window = (cfg_window == '0) ? 1 :
                         (cfg_window > MAX_PERIODS) ? MAX_PERIODS : 32'(cfg_window);
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    t_clock = t_clock + TIME_W'($urandom_range(0, eff_period / 3));
                end else if (r < 70) begin
                    t_clock = t_clock + TIME_W'($urandom_range(0, 2 * eff_period));
                end else if (r < 78) begin
                    // skip several periods, sometimes past the whole window
                    t_clock = t_clock
                              + TIME_W'($urandom_range(1, eff_window + 4) * eff_period
                                        + $urandom_range(0, eff_period - 1));
                end else if (r < 86) begin
                    back = TIME_W'($urandom_range(0, 3 * eff_period));
                    t_clock = (t_clock > back) ? t_clock - back : '0;
                end else if (r < 93) begin
                    t_clock = TIME_W'({$urandom, $urandom});
                end else begin
                    case ($urandom_range(0, 2))
                        0: t_clock = '0;
                        1: t_clock = TIME_MAX;
                        default: t_clock = TIME_MAX
                                           - TIME_W'($urandom_range(0, 3 * eff_period));
                    endcase
                end
                queue_event(t_clock, (k == 0) || ($urandom_range(0, 49) == 0));
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
